// File: hdl/bez_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bezier evaluator package
// Request codes, fixed field widths, fixed-point constants and the
// sequencer state type shared by the Bezier curve evaluator.
// ----------------------------------------------------------------------------
package bez_pkg;

   // Request type codes.
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_EVAL = 1'b1;

   // Fixed field widths.
   localparam int INDEX_WIDTH = 4;
   localparam int NP_WIDTH    = 5;
   localparam int U_WIDTH     = 17;
   localparam int FRAC_BITS   = 16;
   localparam int NUM_AXES    = 2;

   // Parameter u equal to 1.0 and the rounding offset of half an LSB.
   localparam logic [U_WIDTH-1:0]  U_ONE         = 17'd65536;
   localparam logic [FRAC_BITS:0]  ROUND_HALF    = 17'd32768;
   localparam logic [NP_WIDTH-1:0] NP_RESET      = 5'd2;
   localparam logic [NP_WIDTH-1:0] NP_MIN        = 5'd2;

   // Evaluation sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD0,
      ST_LD0,
      ST_MUL,
      ST_WR
   } state_type;

endpackage
`default_nettype wire

// File: hdl/bez_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with the read data registered.
// ----------------------------------------------------------------------------
module bez_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

// File: hdl/bezier_curve_point_eval.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bezier curve point evaluator
// Holds up to MAX_POINTS 2-D control points and evaluates the Bezier curve
// at a parameter u by de Casteljau interpolation in a work memory.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake              Contents
//   req_      in          req_valid / req_stall  load a point or evaluate at u
//   rsp_      out         rsp_valid / rsp_stall  curve_x, curve_y
//   csr_      in          csr_valid / csr_ready  num_points
//
// A load request writes the control point memory.
// An evaluate request with n points in use (n clamped to 2..MAX_POINTS)
// runs n-1 levels: each level fetches its first entry in ST_RD0 and ST_LD0,
// then spends one ST_MUL and ST_WR pair per interpolation step, all on one
// read address shared by both memories and one multiplier per axis.
// Reset is synchronous and active high; it clears the sequencer, the output
// valid and sets num_points to 2. The point memories are not cleared.
// Requests are stalled while an evaluation runs; a result waiting on a
// stalled output holds the last step until the output register is free.
// ----------------------------------------------------------------------------
module bezier_curve_point_eval
   import bez_pkg::*;
#(
   parameter int MAX_POINTS  = 16,
   parameter int COORD_WIDTH = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // Request channel
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic                          req_type,
   input  wire logic [INDEX_WIDTH-1:0]        req_point_index,
   input  wire logic signed [COORD_WIDTH-1:0] req_point_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_point_y,
   input  wire logic [U_WIDTH-1:0]            req_eval_u,
   // Response channel
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic signed [COORD_WIDTH-1:0] rsp_curve_x,
   output      logic signed [COORD_WIDTH-1:0] rsp_curve_y,
   // Configuration channel
   input  wire logic                          csr_valid,
   output      logic                          csr_ready,
   input  wire logic [NP_WIDTH-1:0]           csr_num_points
);

   localparam int W  = COORD_WIDTH;
   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   // Product of |b - a| (W+1 bits) and u, the rounded quotient, the sum.
   localparam int PW = W + 1 + U_WIDTH;
   localparam int QW = PW - FRAC_BITS;
   localparam int RW = QW + 1;
   localparam int DW = NUM_AXES * W;

   localparam logic [W-1:0] COORD_MAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] COORD_MIN = {1'b1, {(W-1){1'b0}}};

   // -------------------------------------------------------------------------
   // Registers
   // -------------------------------------------------------------------------
   state_type             state_ff, state_in;
   logic [NP_WIDTH-1:0]   num_points_ff, num_points_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         lvl_ff, lvl_in;
   logic [AW-1:0]         idx_ff, idx_in;
   logic [U_WIDTH-1:0]    u_ff, u_in;
   logic [W-1:0]          a_ff    [NUM_AXES];
   logic [W-1:0]          a_in    [NUM_AXES];
   logic [W-1:0]          b_ff    [NUM_AXES];
   logic [W-1:0]          b_in    [NUM_AXES];
   logic [PW-1:0]         prod_ff [NUM_AXES];
   logic [PW-1:0]         prod_in [NUM_AXES];
   logic [NUM_AXES-1:0]   neg_ff, neg_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]          rsp_x_ff, rsp_x_in;
   logic [W-1:0]          rsp_y_ff, rsp_y_in;

   // -------------------------------------------------------------------------
   // Memory ports
   // -------------------------------------------------------------------------
   logic          ctl_wr_en;
   logic [AW-1:0] ctl_wr_addr;
   logic [DW-1:0] ctl_wr_data;
   logic [DW-1:0] ctl_rd_data;
   logic          wk_wr_en;
   logic [DW-1:0] wk_wr_data;
   logic [DW-1:0] wk_rd_data;
   logic [AW-1:0] rd_addr;

   // -------------------------------------------------------------------------
   // Datapath signals
   // -------------------------------------------------------------------------
   logic          req_accept;
   logic          eval_accept;
   logic          load_accept;
   logic          out_free;
   logic          level_end;
   logic          last_level;
   logic [AW-1:0] idx_next;
   logic [CW-1:0] count_clamp;
   logic [U_WIDTH-1:0] u_clamp;
   logic [DW-1:0] rd_word;
   logic [W:0]    diff     [NUM_AXES];
   logic [W:0]    mag      [NUM_AXES];
   logic [QW-1:0] quot     [NUM_AXES];
   logic [RW-1:0] sum      [NUM_AXES];
   logic [W-1:0]  step_val [NUM_AXES];

   assign req_accept  = req_valid && !req_stall;
   assign eval_accept = req_accept && (req_type == REQ_EVAL);
   assign load_accept = req_accept && (req_type == REQ_LOAD);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign idx_next    = idx_ff + 1'b1;
   assign level_end   = (CW'(idx_ff) + 1'b1) == (count_ff - lvl_ff);
   assign last_level  = lvl_ff == (count_ff - 1'b1);

   // The first level interpolates the stored control points; every later
   // level works on the intermediate points of the level before.
   assign rd_word = (lvl_ff == CW'(1)) ? ctl_rd_data : wk_rd_data;

   // Clamp the point count and the parameter once, at request time.
   always_comb begin
      if (num_points_ff < NP_MIN) begin
         count_clamp = CW'(NP_MIN);
      end else if (num_points_ff > MAX_POINTS) begin
         count_clamp = CW'(MAX_POINTS);
      end else begin
         count_clamp = CW'(num_points_ff);
      end
      u_clamp = (req_eval_u > U_ONE) ? U_ONE : req_eval_u;
   end

   // One interpolation step per axis: a + round(|b - a| * u / 2^16) with the
   // sign of b - a. The multiply is registered before the add and clamp.
   always_comb begin
      for (int k = 0; k < NUM_AXES; k++) begin
         diff[k] = {rd_word[k*W + W-1], rd_word[k*W +: W]} - {a_ff[k][W-1], a_ff[k]};
         mag[k]  = diff[k][W] ? (~diff[k] + 1'b1) : diff[k];
         quot[k] = QW'((prod_ff[k] + PW'(ROUND_HALF)) >> FRAC_BITS);
         if (neg_ff[k]) begin
            sum[k] = {{(RW-W){a_ff[k][W-1]}}, a_ff[k]} - {1'b0, quot[k]};
         end else begin
            sum[k] = {{(RW-W){a_ff[k][W-1]}}, a_ff[k]} + {1'b0, quot[k]};
         end
         // Saturate to the coordinate range when the upper bits disagree.
         if ((&sum[k][RW-1:W-1]) || !(|sum[k][RW-1:W-1])) begin
            step_val[k] = sum[k][W-1:0];
         end else begin
            step_val[k] = sum[k][RW-1] ? COORD_MIN : COORD_MAX;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Sequencer: next state
   // -------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (eval_accept) begin
               state_in = ST_RD0;
            end
         end
         ST_RD0: begin
            state_in = ST_LD0;
         end
         ST_LD0: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_WR;
         end
         ST_WR: begin
            if (!level_end) begin
               state_in = ST_MUL;
            end else if (!last_level) begin
               state_in = ST_RD0;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // -------------------------------------------------------------------------
   // Sequencer: outputs and memory control
   // -------------------------------------------------------------------------
   always_comb begin
      req_stall = 1'b1;
      ctl_wr_en = 1'b0;
      wk_wr_en  = 1'b0;
      rd_addr   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            ctl_wr_en = load_accept && (req_point_index < MAX_POINTS);
         end
         ST_RD0: begin
            rd_addr = '0;
         end
         ST_LD0: begin
            rd_addr = AW'(1);
         end
         ST_MUL: begin
            rd_addr = idx_next;
         end
         ST_WR: begin
            // Fetch the right-hand operand of the next step while the
            // current result goes back over the left-hand entry.
            rd_addr  = idx_next + 1'b1;
            wk_wr_en = !last_level;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign ctl_wr_addr = AW'(req_point_index);
   assign ctl_wr_data = {req_point_y, req_point_x};
   assign csr_ready   = 1'b1;

   always_comb begin
      for (int k = 0; k < NUM_AXES; k++) begin
         wk_wr_data[k*W +: W] = step_val[k];
      end
   end

   // -------------------------------------------------------------------------
   // Next values of the datapath and control registers
   // -------------------------------------------------------------------------
   always_comb begin
      num_points_in = num_points_ff;
      count_in      = count_ff;
      lvl_in        = lvl_ff;
      idx_in        = idx_ff;
      u_in          = u_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      prod_in       = prod_ff;
      neg_in        = neg_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;

      if (csr_valid && csr_ready) begin
         num_points_in = csr_num_points;
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (eval_accept) begin
               count_in = count_clamp;
               u_in     = u_clamp;
               lvl_in   = CW'(1);
            end
         end
         ST_RD0: begin
            idx_in = '0;
         end
         ST_LD0: begin
            for (int k = 0; k < NUM_AXES; k++) begin
               a_in[k] = rd_word[k*W +: W];
            end
         end
         ST_MUL: begin
            for (int k = 0; k < NUM_AXES; k++) begin
               b_in[k]    = rd_word[k*W +: W];
               prod_in[k] = mag[k] * u_ff;
               neg_in[k]  = diff[k][W];
            end
         end
         ST_WR: begin
            if (!level_end) begin
               idx_in = idx_next;
               a_in   = b_ff;
            end else if (!last_level) begin
               lvl_in = lvl_ff + 1'b1;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = step_val[0];
               rsp_y_in     = step_val[1];
            end
         end
         default: begin
            lvl_in = lvl_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         num_points_ff <= NP_RESET;
         count_ff      <= CW'(NP_RESET);
         lvl_ff        <= CW'(1);
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         num_points_ff <= num_points_in;
         count_ff      <= count_in;
         lvl_ff        <= lvl_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff     <= u_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      prod_ff  <= prod_in;
      neg_ff   <= neg_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_curve_x = rsp_x_ff;
   assign rsp_curve_y = rsp_y_ff;

   // -------------------------------------------------------------------------
   // Control point memory and work memory
   // -------------------------------------------------------------------------
   bez_ram #(
      .WIDTH (DW),
      .DEPTH (MAX_POINTS)
   ) u_ctl_ram (
      .clock   (clock),
      .wr_en   (ctl_wr_en),
      .wr_addr (ctl_wr_addr),
      .wr_data (ctl_wr_data),
      .rd_addr (rd_addr),
      .rd_data (ctl_rd_data)
   );

   bez_ram #(
      .WIDTH (DW),
      .DEPTH (MAX_POINTS)
   ) u_work_ram (
      .clock   (clock),
      .wr_en   (wk_wr_en),
      .wr_addr (idx_ff),
      .wr_data (wk_wr_data),
      .rd_addr (rd_addr),
      .rd_data (wk_rd_data)
   );

`ifndef SYNTHESIS
   // The level counter stays within the degree of the curve while busy.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (lvl_ff != '0) && (lvl_ff < count_ff))
      else $error("level counter outside the curve degree");

   // A step never reaches past the last pair of its level.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> ((CW'(idx_ff) + 1'b1) <= (count_ff - lvl_ff)))
      else $error("step index beyond the end of its level");

   // An evaluate request starts at level one with a clamped point count.
   assert property (@(posedge clock) disable iff (reset)
      eval_accept |=> (state_ff == ST_RD0) && (lvl_ff == CW'(1)) &&
                      (count_ff >= CW'(NP_MIN)) && (count_ff <= MAX_POINTS))
      else $error("evaluation started with a bad level or point count");

   // A new result appears only out of the final step of the last level.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |->
         ($past(state_ff) == ST_WR) && $past(last_level))
      else $error("result raised outside the final interpolation step");
`endif

endmodule
`default_nettype wire
